// File: rtl/fpa_pkg.sv
// fpa_pkg: shared types and constants for the fixed-point ALU pipeline.
// No dependencies; used by every module of the block.
package fpa_pkg;

	localparam int WORD_W        = 32;
	localparam int FUNC_W        = 4;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_LT  = 4'd4,
		OP_GT  = 4'd5,
		OP_EQ  = 4'd6,
		OP_LE  = 4'd7,
		OP_GE  = 4'd8
	} alu_op_t;

	// input item
	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [WORD_W-1:0] operand_a;
		logic signed [WORD_W-1:0] operand_b;
	} req_t;

	// result item
	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     cmp_true;
	} rsp_t;

	// control and partial result carried down the pipeline
	typedef struct packed {
		logic [FUNC_W-1:0] op;
		logic [WORD_W-1:0] value;    // final value for add/sub/compare, mul after s3
		logic              cmp;
		logic              neg;      // sign of product or quotient
		logic [WORD_W-1:0] divisor;  // |b|, or one for a zero divisor
	} ctl_t;

endpackage

// File: rtl/fpa_front.sv
// fpa_front: stage 1, decode, add/sub, compares, operand magnitudes.
// Depends on fpa_pkg.
module fpa_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fpa_pkg::req_t req,
	output logic          s1_valid,
	input  logic          s1_ready,
	output fpa_pkg::ctl_t s1_ctl,
	output logic [fpa_pkg::WORD_W-1:0] s1_mag_a
);

	logic                       vld_s1;
	fpa_pkg::ctl_t              ctl_s1;
	logic [fpa_pkg::WORD_W-1:0] mag_a_s1;

	fpa_pkg::ctl_t              ctl_d;
	logic [fpa_pkg::WORD_W-1:0] mag_a_d;
	logic [fpa_pkg::WORD_W-1:0] mag_b_d;
	logic                       zero_div;

	assign req_ready = !vld_s1 || s1_ready;

	always_comb begin
		mag_a_d  = req.operand_a[fpa_pkg::WORD_W-1] ? (~req.operand_a + 1'b1) : req.operand_a;
		mag_b_d  = req.operand_b[fpa_pkg::WORD_W-1] ? (~req.operand_b + 1'b1) : req.operand_b;
		zero_div = (req.func == fpa_pkg::OP_DIV) && (req.operand_b == '0);

		ctl_d.op      = req.func;
		ctl_d.value   = '0;
		ctl_d.cmp     = 1'b0;
		ctl_d.divisor = zero_div ? fpa_pkg::WORD_W'(1) : mag_b_d;
		ctl_d.neg     = zero_div ? req.operand_a[fpa_pkg::WORD_W-1]
		                         : (req.operand_a[fpa_pkg::WORD_W-1] ^
		                            req.operand_b[fpa_pkg::WORD_W-1]);

		unique case (req.func)
			fpa_pkg::OP_ADD: ctl_d.value = req.operand_a + req.operand_b;
			fpa_pkg::OP_SUB: ctl_d.value = req.operand_a - req.operand_b;
			fpa_pkg::OP_LT:  ctl_d.cmp   = req.operand_a <  req.operand_b;
			fpa_pkg::OP_GT:  ctl_d.cmp   = req.operand_a >  req.operand_b;
			fpa_pkg::OP_EQ:  ctl_d.cmp   = req.operand_a == req.operand_b;
			fpa_pkg::OP_LE:  ctl_d.cmp   = req.operand_a <= req.operand_b;
			fpa_pkg::OP_GE:  ctl_d.cmp   = req.operand_a >= req.operand_b;
			default: begin
				// mul, div finish later; unused codes give zeros
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			ctl_s1   <= ctl_d;
			mag_a_s1 <= mag_a_d;
		end
	end

	assign s1_valid = vld_s1;
	assign s1_ctl   = ctl_s1;
	assign s1_mag_a = mag_a_s1;

endmodule

// File: rtl/fpa_mul.sv
// fpa_mul: stages 2 and 3, 32x32 magnitude product, scaling and sign, and
// the dividend setup for the divider. Depends on fpa_pkg.
module fpa_mul #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s1_valid,
	output logic          s1_ready,
	input  fpa_pkg::ctl_t s1_ctl,
	input  logic [fpa_pkg::WORD_W-1:0] s1_mag_a,
	output logic          s3_valid,
	input  logic          s3_ready,
	output fpa_pkg::ctl_t s3_ctl,
	output logic [fpa_pkg::WORD_W+FRAC_BITS-1:0] s3_dividend
);

	localparam int W  = fpa_pkg::WORD_W;
	localparam int DW = W + FRAC_BITS;

	logic              vld_s2;
	logic              rdy_s2;
	fpa_pkg::ctl_t     ctl_s2;
	logic [W-1:0]      mag_a_s2;
	logic [2*W-1:0]    prod_s2;

	logic              vld_s3;
	fpa_pkg::ctl_t     ctl_s3;
	logic [DW-1:0]     dvd_s3;

	fpa_pkg::ctl_t     ctl_d;
	logic [W-1:0]      scaled;

	assign s3_valid = vld_s3;
	assign rdy_s2   = !vld_s3 || s3_ready;
	assign s1_ready = !vld_s2 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (s1_ready) begin
				vld_s2 <= s1_valid;
			end
			if (rdy_s2) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			ctl_s2   <= s1_ctl;
			mag_a_s2 <= s1_mag_a;
			prod_s2  <= {{W{1'b0}}, s1_mag_a} * {{W{1'b0}}, s1_ctl.divisor};
		end
	end

	// truncation toward zero: scale the magnitude, then apply the sign
	always_comb begin
		scaled = prod_s2[FRAC_BITS +: W];
		ctl_d  = ctl_s2;
		if (ctl_s2.op == fpa_pkg::OP_MUL) begin
			ctl_d.value = ctl_s2.neg ? (~scaled + 1'b1) : scaled;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s2) begin
			ctl_s3 <= ctl_d;
			dvd_s3 <= {mag_a_s2, {FRAC_BITS{1'b0}}};
		end
	end

	assign s3_ctl      = ctl_s3;
	assign s3_dividend = dvd_s3;

endmodule

// File: rtl/fpa_div.sv
// fpa_div: restoring divider, one quotient bit per pipeline stage, followed by
// the sign/select output stage. Depends on fpa_pkg.
module fpa_div #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s3_valid,
	output logic          s3_ready,
	input  fpa_pkg::ctl_t s3_ctl,
	input  logic [fpa_pkg::WORD_W+FRAC_BITS-1:0] s3_dividend,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fpa_pkg::rsp_t rsp
);

	localparam int W  = fpa_pkg::WORD_W;
	localparam int DW = W + FRAC_BITS;

	// step k holds the partial remainder and the shifting dividend/quotient word
	logic          vld_s [1:DW];
	fpa_pkg::ctl_t ctl_s [1:DW];
	logic [DW-1:0] qd_s  [1:DW];
	logic [W-1:0]  rem_s [1:DW];
	logic          rdy   [1:DW+1];

	logic          vld_out_q;
	fpa_pkg::rsp_t rsp_q;

	assign s3_ready   = rdy[1];
	assign rdy[DW+1]  = !vld_out_q || rsp_ready;

	for (genvar k = 1; k <= DW; k++) begin : g_step
		logic          p_vld;
		fpa_pkg::ctl_t p_ctl;
		logic [DW-1:0] p_qd;
		logic [W-1:0]  p_rem;
		logic [W:0]    trial;
		logic [W:0]    diff;
		logic          ge;

		if (k == 1) begin : g_first
			assign p_vld = s3_valid;
			assign p_ctl = s3_ctl;
			assign p_qd  = s3_dividend;
			assign p_rem = '0;
		end else begin : g_next
			assign p_vld = vld_s[k-1];
			assign p_ctl = ctl_s[k-1];
			assign p_qd  = qd_s[k-1];
			assign p_rem = rem_s[k-1];
		end

		assign trial  = {p_rem, p_qd[DW-1]};
		assign diff   = trial - {1'b0, p_ctl.divisor};
		assign ge     = trial >= {1'b0, p_ctl.divisor};
		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= p_vld;
			end
		end

		// remainder stays below the divisor, so 32 bits hold it
		always_ff @(posedge clk) begin
			if (p_vld && rdy[k]) begin
				ctl_s[k] <= p_ctl;
				qd_s[k]  <= {p_qd[DW-2:0], ge};
				rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
			end
		end
	end

	fpa_pkg::rsp_t rsp_d;
	logic [W-1:0]  quot;

	always_comb begin
		quot           = qd_s[DW][W-1:0];
		rsp_d.cmp_true = ctl_s[DW].cmp;
		if (ctl_s[DW].op == fpa_pkg::OP_DIV) begin
			rsp_d.value = ctl_s[DW].neg ? (~quot + 1'b1) : quot;
		end else begin
			rsp_d.value = ctl_s[DW].value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (rdy[DW+1]) begin
			vld_out_q <= vld_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[DW] && rdy[DW+1]) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = vld_out_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/fixed_point_alu.sv
// Signed fixed-point ALU (add, sub, mul, div, five compares) on 32-bit words
// with FRAC_BITS fraction bits. One item in and one result out per cycle
// while the output is not stalled. The pipeline has one decode stage,
// two multiplier stages, one restoring-divider stage per bit of the
// 32 + FRAC_BITS bit dividend, and an output stage. Every opcode takes the same
// path, so results leave in order. Each stage has its own valid bit and takes
// a new item whenever it is empty or moves on, so bubbles are squeezed out
// while the output is stalled. Depends on fpa_pkg, fpa_front, fpa_mul, fpa_div.
module fixed_point_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fpa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fpa_pkg::rsp_t rsp
);

	logic                                 s1_valid;
	logic                                 s1_ready;
	fpa_pkg::ctl_t                        s1_ctl;
	logic [fpa_pkg::WORD_W-1:0]           s1_mag_a;
	logic                                 s3_valid;
	logic                                 s3_ready;
	fpa_pkg::ctl_t                        s3_ctl;
	logic [fpa_pkg::WORD_W+FRAC_BITS-1:0] s3_dividend;

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_ctl    (s1_ctl),
		.s1_mag_a  (s1_mag_a)
	);

	fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (s1_valid),
		.s1_ready    (s1_ready),
		.s1_ctl      (s1_ctl),
		.s1_mag_a    (s1_mag_a),
		.s3_valid    (s3_valid),
		.s3_ready    (s3_ready),
		.s3_ctl      (s3_ctl),
		.s3_dividend (s3_dividend)
	);

	fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.s3_valid    (s3_valid),
		.s3_ready    (s3_ready),
		.s3_ctl      (s3_ctl),
		.s3_dividend (s3_dividend),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule

// File: bench/tb.sv
// tb: self-checking bench for fixed_point_alu (add, sub, Q16.16 mul and div, compares).
// Holds its own prediction of every result and compares results in order of arrival.
// Depends on fpa_pkg and fixed_point_alu.
module tb;

	localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;
	localparam logic [fpa_pkg::FUNC_W-1:0] FUNC_FIRST_UNUSED =
		fpa_pkg::FUNC_W'(fpa_pkg::OP_GE) + 1'b1;
	localparam logic [fpa_pkg::FUNC_W-1:0] FUNC_LAST_CODE = '1;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		fpa_pkg::req_t stim;
		fpa_pkg::rsp_t want;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	fpa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	fpa_pkg::rsp_t rsp;

	pending_t pending_q[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;

	fixed_point_alu #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] word_mag(logic [fpa_pkg::WORD_W-1:0] w);
		return {32'd0, (w[fpa_pkg::WORD_W-1] ? (~w + 32'd1) : w)};
	endfunction

	function automatic fpa_pkg::rsp_t alu_predict(fpa_pkg::req_t r);
		logic [fpa_pkg::WORD_W-1:0] a, b;
		logic [63:0] mag_a, mag_b, den, wide;
		logic neg;
		fpa_pkg::rsp_t res;
		a = r.operand_a;
		b = r.operand_b;
		mag_a = word_mag(a);
		mag_b = word_mag(b);
		res = '0;
		case (r.func)
			fpa_pkg::OP_ADD: res.value = a + b;
			fpa_pkg::OP_SUB: res.value = a - b;
			fpa_pkg::OP_MUL: begin
				neg = a[fpa_pkg::WORD_W-1] ^ b[fpa_pkg::WORD_W-1];
				wide = (mag_a * mag_b) >> FRAC;
				res.value = neg ? (~wide[31:0] + 32'd1) : wide[31:0];
			end
			fpa_pkg::OP_DIV: begin
				// zero divisor acts as one
				den = (b == '0) ? 64'd1 : mag_b;
				neg = (b == '0) ? a[fpa_pkg::WORD_W-1]
				                : (a[fpa_pkg::WORD_W-1] ^ b[fpa_pkg::WORD_W-1]);
				wide = (mag_a << FRAC) / den;
				res.value = neg ? (~wide[31:0] + 32'd1) : wide[31:0];
			end
			fpa_pkg::OP_LT: res.cmp_true = r.operand_a < r.operand_b;
			fpa_pkg::OP_GT: res.cmp_true = r.operand_a > r.operand_b;
			fpa_pkg::OP_EQ: res.cmp_true = r.operand_a == r.operand_b;
			fpa_pkg::OP_LE: res.cmp_true = r.operand_a <= r.operand_b;
			fpa_pkg::OP_GE: res.cmp_true = r.operand_a >= r.operand_b;
			default: res = '0;
		endcase
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [fpa_pkg::WORD_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
			1, 2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return 32'((int'($urandom_range(0, 200)) - 100) <<< FRAC);
			default: return $urandom();
		endcase
	endfunction

	// receiver: runs of ready broken by stalls while recv_idle is set, else always ready
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!recv_idle || !rsp_ready) begin
			rsp_ready <= 1'b1;
			hold_left <= $urandom_range(0, 6);
		end else begin
			rsp_ready <= 1'b0;
			hold_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		pending_t head;
		if (req_valid && req_ready)
			pending_q.push_back(pending_t'{stim: req, want: alu_predict(req)});
		if (rsp_valid && rsp_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing pending: value %h cmp %b",
					$time, rsp.value, rsp.cmp_true);
				mismatches++;
			end else begin
				head = pending_q.pop_front();
				if (rsp.value !== head.want.value) begin
					$display("%0t: value mismatch func %0d a %h b %h: expected %h, actual %h",
						$time, head.stim.func, head.stim.operand_a, head.stim.operand_b,
						head.want.value, rsp.value);
					mismatches++;
				end
				if (rsp.cmp_true !== head.want.cmp_true) begin
					$display("%0t: cmp_true mismatch func %0d a %h b %h: expected %b, actual %b",
						$time, head.stim.func, head.stim.operand_a, head.stim.operand_b,
						head.want.cmp_true, rsp.cmp_true);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_item(logic [fpa_pkg::FUNC_W-1:0] func,
			logic [fpa_pkg::WORD_W-1:0] a, logic [fpa_pkg::WORD_W-1:0] b);
		int gap;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= '{func: func, operand_a: a, operand_b: b};
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic send_random_item();
		logic [fpa_pkg::FUNC_W-1:0] func;
		logic [fpa_pkg::WORD_W-1:0] a, b;
		if ($urandom_range(0, 9) == 0)
			func = fpa_pkg::FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_CODE));
		else
			func = fpa_pkg::FUNC_W'($urandom_range(fpa_pkg::OP_ADD, fpa_pkg::OP_GE));
		a = pick_operand();
		b = pick_operand();
		case ($urandom_range(0, 19))
			0, 1, 2: b = a;
			3: b = '0;
			default: ;
		endcase
		send_item(func, a, b);
	endtask

	task automatic test_directed();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_item(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
		send_item(fpa_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000);
		send_item(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
		send_item(fpa_pkg::OP_SUB, 32'h0000_0000, 32'h8000_0000);
		send_item(fpa_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000);
		send_item(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_item(fpa_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001);
		send_item(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'hffff_0000);
		send_item(fpa_pkg::OP_DIV, 32'h0003_0000, 32'h0000_0000);
		send_item(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000);
		send_item(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_item(fpa_pkg::OP_DIV, 32'hffff_ffff, 32'h0002_0000);
		send_item(fpa_pkg::OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7fff_ffff);
		send_item(fpa_pkg::OP_GT, 32'h8000_0000, 32'h7fff_ffff);
		send_item(fpa_pkg::OP_EQ, 32'h1234_5678, 32'h1234_5678);
		send_item(fpa_pkg::OP_LE, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(fpa_pkg::OP_GE, 32'h8000_0000, 32'h8000_0000);
		send_item(fpa_pkg::OP_LT, 32'h0000_0005, 32'h0000_0005);
		send_item(fpa_pkg::OP_GT, 32'hffff_ffff, 32'h0000_0000);
		send_item(fpa_pkg::OP_EQ, 32'h0000_0000, 32'h8000_0000);
		send_item(FUNC_FIRST_UNUSED, 32'h7fff_ffff, 32'h8000_0000);
		send_item(FUNC_LAST_CODE, 32'hffff_ffff, 32'hffff_ffff);
	endtask

	task automatic test_random_mix(int count);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (count) send_random_item();
	endtask

	task automatic test_full_rate(int count);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		repeat (count) send_random_item();
	endtask

	// sender never pauses while the output stalls, so the pipeline fills up
	task automatic test_output_backpressure(int count);
		send_idle = 1'b0;
		recv_idle = 1'b1;
		repeat (count) send_random_item();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_mix(450);
		test_full_rate(400);
		test_output_backpressure(400);
		req_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_q.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
